[hdl/tgrf_pkg.sv]
package tgrf_pkg;

    // glow geometry
    localparam int GLOW_RADIUS = 10;
    localparam int WIN_LEN     = 2 * GLOW_RADIUS + 1;
    localparam int SEEN_W      = $clog2(GLOW_RADIUS + 1);
    localparam int CNT_W       = $clog2(GLOW_RADIUS + 2);

    // pixel format and blend constants
    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int CH_NUM      = PIX_W / CH_W;
    localparam int CH_MAX      = 255;
    localparam int ALPHA_STEP  = 10;
    localparam logic [PIX_W-1:0] PIX_MASK = 24'hFFFFFF;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [SEEN_W-1:0] seen_t;
    typedef logic [CNT_W-1:0]  count_t;

    // one input transaction as held in the input register
    typedef struct packed {
        pixel_t pixel;
        logic   first;
        logic   last;
    } item_t;

    // one output transaction
    typedef struct packed {
        pixel_t pixel;
        logic   last;
    } result_t;

    // all results one input transaction can produce, first at index 0
    typedef result_t [GLOW_RADIUS:0] result_vec_t;

endpackage

[hdl/tgrf_input.sv]
module tgrf_input (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tgrf_pkg::pixel_t pixel_value,
    input  logic             frame_first,
    input  logic             row_last,
    input  logic             ready,
    output logic             item_valid,
    output tgrf_pkg::item_t  item
);

    logic            valid_reg;
    logic            valid_next;
    tgrf_pkg::item_t item_reg;
    logic            accept;

    // hold off new transactions only while the held one cannot move on
    assign in_stall   = valid_reg && !ready;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept || (valid_reg && !ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.pixel <= pixel_value;
            item_reg.first <= frame_first;
            item_reg.last  <= row_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/tgrf_window.sv]
module tgrf_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  tgrf_pkg::pixel_t      cfg_data,
    input  logic                  step,
    input  tgrf_pkg::item_t       item,
    output tgrf_pkg::result_vec_t res,
    output tgrf_pkg::count_t      res_n
);

    tgrf_pkg::pixel_t win_reg  [tgrf_pkg::WIN_LEN];
    tgrf_pkg::pixel_t win_next [tgrf_pkg::WIN_LEN];
    tgrf_pkg::pixel_t win_eff  [tgrf_pkg::WIN_LEN];
    tgrf_pkg::pixel_t win_bl   [tgrf_pkg::WIN_LEN];
    tgrf_pkg::seen_t  seen_reg;
    tgrf_pkg::seen_t  seen_next;
    tgrf_pkg::seen_t  seen_eff;
    logic             odd_reg;
    logic             odd_next;
    logic             odd_eff;
    tgrf_pkg::pixel_t glow_reg;
    logic             match;

    // alpha for a neighbor at distance d, nearest strongest
    function automatic logic [tgrf_pkg::CH_W-1:0] glow_alpha(input int d);
        return tgrf_pkg::CH_W'(tgrf_pkg::ALPHA_STEP * (tgrf_pkg::GLOW_RADIUS - d + 1));
    endfunction

    // per channel blend of the glow color onto an accumulator
    function automatic tgrf_pkg::pixel_t blend_pixel(
        input tgrf_pkg::pixel_t           acc,
        input tgrf_pkg::pixel_t           color,
        input logic [tgrf_pkg::CH_W-1:0]  alpha
    );
        logic [2*tgrf_pkg::CH_W-1:0] pa;
        logic [2*tgrf_pkg::CH_W-1:0] pb;
        logic [tgrf_pkg::CH_W:0]     sum;
        logic [tgrf_pkg::CH_W-1:0]   inv;
        tgrf_pkg::pixel_t            blended;
        inv     = tgrf_pkg::CH_W'(tgrf_pkg::CH_MAX) - alpha;
        blended = '0;
        for (int s = 0; s < tgrf_pkg::CH_NUM; s++)
        begin
            pa  = alpha * color[s*tgrf_pkg::CH_W +: tgrf_pkg::CH_W];
            pb  = inv * acc[s*tgrf_pkg::CH_W +: tgrf_pkg::CH_W];
            sum = {1'b0, pa[2*tgrf_pkg::CH_W-1:tgrf_pkg::CH_W]}
                + {1'b0, pb[2*tgrf_pkg::CH_W-1:tgrf_pkg::CH_W]};
            blended[s*tgrf_pkg::CH_W +: tgrf_pkg::CH_W] = sum[tgrf_pkg::CH_W-1:0];
        end
        return blended;
    endfunction

    // frame start clears the row before anything else
    always_comb
    begin
        seen_eff = item.first ? '0 : seen_reg;
        odd_eff  = item.first ? 1'b0 : odd_reg;
        for (int k = 0; k < tgrf_pkg::WIN_LEN; k++)
        begin
            win_eff[k] = item.first ? '0 : win_reg[k];
        end
    end

    assign match = (item.pixel == glow_reg);

    // glow blends onto both sides, left side only inside the row
    always_comb
    begin
        for (int k = 0; k < tgrf_pkg::WIN_LEN; k++)
        begin
            win_bl[k] = win_eff[k];
            if (match)
            begin
                if (k > tgrf_pkg::GLOW_RADIUS)
                begin
                    win_bl[k] = blend_pixel(win_eff[k], glow_reg,
                                            glow_alpha(k - tgrf_pkg::GLOW_RADIUS));
                end
                else if (k < tgrf_pkg::GLOW_RADIUS)
                begin
                    if (int'(seen_eff) >= tgrf_pkg::GLOW_RADIUS - k)
                    begin
                        win_bl[k] = blend_pixel(win_eff[k], glow_reg,
                                                glow_alpha(tgrf_pkg::GLOW_RADIUS - k));
                    end
                end
                else
                begin
                    win_bl[k] = item.pixel;
                end
            end
        end
    end

    // results and next row state
    always_comb
    begin
        win_next  = win_reg;
        seen_next = seen_reg;
        odd_next  = odd_reg;
        res       = '0;
        res_n     = '0;
        if (step)
        begin
            if (odd_eff)
            begin
                // odd row passes straight through
                res[0].pixel = item.pixel;
                res[0].last  = item.last;
                res_n        = tgrf_pkg::CNT_W'(1);
                if (item.last)
                begin
                    for (int k = 0; k < tgrf_pkg::WIN_LEN; k++)
                    begin
                        win_next[k] = '0;
                    end
                    seen_next = '0;
                    odd_next  = 1'b0;
                end
            end
            else if (item.last)
            begin
                // flush the pending part of the row up to the current pixel
                for (int s = 0; s <= tgrf_pkg::GLOW_RADIUS; s++)
                begin
                    if (seen_eff == tgrf_pkg::SEEN_W'(s))
                    begin
                        for (int j = 0; j <= s; j++)
                        begin
                            res[j].pixel = win_bl[tgrf_pkg::GLOW_RADIUS - s + j];
                            res[j].last  = (j == s);
                        end
                        res_n = tgrf_pkg::CNT_W'(s + 1);
                    end
                end
                for (int k = 0; k < tgrf_pkg::WIN_LEN; k++)
                begin
                    win_next[k] = '0;
                end
                seen_next = '0;
                odd_next  = 1'b1;
            end
            else
            begin
                // oldest position leaves once the window is full
                if (seen_eff == tgrf_pkg::SEEN_W'(tgrf_pkg::GLOW_RADIUS))
                begin
                    res[0].pixel = win_bl[0];
                    res[0].last  = 1'b0;
                    res_n        = tgrf_pkg::CNT_W'(1);
                    seen_next    = seen_eff;
                end
                else
                begin
                    seen_next = seen_eff + 1'b1;
                end
                for (int k = 0; k < tgrf_pkg::WIN_LEN - 1; k++)
                begin
                    win_next[k] = win_bl[k + 1];
                end
                win_next[tgrf_pkg::WIN_LEN-1] = '0;
                odd_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tgrf_pkg::WIN_LEN; k++)
            begin
                win_reg[k] <= '0;
            end
            seen_reg <= '0;
            odd_reg  <= 1'b0;
            glow_reg <= tgrf_pkg::PIX_MASK;
        end
        else
        begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
            odd_reg  <= odd_next;
            if (cfg_write)
            begin
                glow_reg <= cfg_data;
            end
        end
    end

endmodule

[hdl/tgrf_out.sv]
module tgrf_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tgrf_pkg::result_vec_t res,
    input  tgrf_pkg::count_t      res_n,
    output logic                  ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tgrf_pkg::pixel_t      out_pixel,
    output logic                  out_row_last
);

    tgrf_pkg::result_vec_t buf_reg;
    tgrf_pkg::result_vec_t buf_next;
    tgrf_pkg::count_t      cnt_reg;
    tgrf_pkg::count_t      cnt_next;
    tgrf_pkg::result_t     o_reg;
    tgrf_pkg::result_t     o_next;
    logic                  o_valid_reg;
    logic                  o_valid_next;
    logic                  o_free;

    assign o_free = !o_valid_reg || !out_stall;
    assign ready  = (cnt_reg == '0);

    // drain buffer into the output register, or load fresh results
    always_comb
    begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        o_next       = o_reg;
        o_valid_next = o_valid_reg;
        if (cnt_reg != '0)
        begin
            if (o_free)
            begin
                o_next       = buf_reg[0];
                o_valid_next = 1'b1;
                for (int j = 0; j < tgrf_pkg::GLOW_RADIUS; j++)
                begin
                    buf_next[j] = buf_reg[j + 1];
                end
                buf_next[tgrf_pkg::GLOW_RADIUS] = '0;
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (push && (res_n != '0))
        begin
            if (o_free)
            begin
                o_next       = res[0];
                o_valid_next = 1'b1;
                for (int j = 0; j < tgrf_pkg::GLOW_RADIUS; j++)
                begin
                    buf_next[j] = res[j + 1];
                end
                buf_next[tgrf_pkg::GLOW_RADIUS] = '0;
                cnt_next = res_n - 1'b1;
            end
            else
            begin
                buf_next = res;
                cnt_next = res_n;
            end
        end
        else if (o_free)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        o_reg   <= o_next;
    end

    assign out_valid    = o_valid_reg;
    assign out_pixel    = o_reg.pixel;
    assign out_row_last = o_reg.last;

endmodule

[hdl/text_glow_row_filter.sv]
// channel   handshake             payload
// -------   -------------------   -------------------------------------
// input     in_valid / in_stall   pixel_value, frame_first, row_last
// output    out_valid / out_stall out_pixel, out_row_last
// config    cfg_write             cfg_data (glow color)
//
// one pixel per cycle while in_stall is low; input and output are both registered
// the row_last flush of an even row yields up to 11 results, drained one per cycle from
// the result buffer unless stalled; input register holds its item till the buffer empties
// reset clears window, pixel count, row parity, buffer count; glow color resets to white
// a stalled output holds; input stalls once a result waits behind it and a pixel is held
module text_glow_row_filter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  tgrf_pkg::pixel_t cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  tgrf_pkg::pixel_t pixel_value,
    input  logic             frame_first,
    input  logic             row_last,
    output logic             out_valid,
    input  logic             out_stall,
    output tgrf_pkg::pixel_t out_pixel,
    output logic             out_row_last
);

    logic                  ready;
    logic                  item_valid;
    tgrf_pkg::item_t       item;
    logic                  step;
    tgrf_pkg::result_vec_t res;
    tgrf_pkg::count_t      res_n;

    // held pixel moves on when the result buffer is empty
    assign step = item_valid && ready;

    tgrf_input u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .frame_first (frame_first),
        .row_last    (row_last),
        .ready       (ready),
        .item_valid  (item_valid),
        .item        (item)
    );

    tgrf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item),
        .res       (res),
        .res_n     (res_n)
    );

    tgrf_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (step),
        .res          (res),
        .res_n        (res_n),
        .ready        (ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_pixel    (out_pixel),
        .out_row_last (out_row_last)
    );

endmodule

[hdl/tgrf_checker.sv]
module tgrf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input tgrf_pkg::pixel_t pixel_value,
    input logic             frame_first,
    input logic             row_last,
    input logic             out_valid,
    input logic             out_stall,
    input tgrf_pkg::pixel_t out_pixel,
    input logic             out_row_last
);

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(pixel_value)
            && $stable(frame_first) && $stable(row_last))
        else $error("stalled input transaction changed");

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(out_row_last))
        else $error("stalled output transaction changed");

    // input is only held back while results are queued behind the output register
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output pending");

    // stall starts only right after an accepted input transaction
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without a preceding transaction");

endmodule

bind text_glow_row_filter tgrf_checker u_checker (.*);
